// ----- rtl/core/lcl_pkg.sv -----
// Shared types and constants for the character lexer.
// Depends on nothing; used by lcl_out_if and every core module.
package lcl_pkg;

  localparam int KIND_W  = 6;
  localparam int OFFS_W  = 24;
  localparam int LEN_W   = 24;
  localparam int LINE_W  = 16;
  localparam int ERR_W   = 2;
  localparam int MAX_RES = 3;

  localparam logic [3:0] M_IDLE      = 4'd0;
  localparam logic [3:0] M_BANG      = 4'd1;
  localparam logic [3:0] M_EQUAL     = 4'd2;
  localparam logic [3:0] M_GREATER   = 4'd3;
  localparam logic [3:0] M_LESS      = 4'd4;
  localparam logic [3:0] M_SLASH     = 4'd5;
  localparam logic [3:0] M_LINECOM   = 4'd6;
  localparam logic [3:0] M_BLOCK     = 4'd7;
  localparam logic [3:0] M_BLOCKSTAR = 4'd8;
  localparam logic [3:0] M_STRING    = 4'd9;
  localparam logic [3:0] M_NUM       = 4'd10;
  localparam logic [3:0] M_NUMDOT    = 4'd11;
  localparam logic [3:0] M_NUMFRAC   = 4'd12;
  localparam logic [3:0] M_WORD      = 4'd13;

  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COMMA   = 6'd4;
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_MINUS   = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd7;
  localparam logic [5:0] K_SEMI    = 6'd8;
  localparam logic [5:0] K_STAR    = 6'd9;
  localparam logic [5:0] K_QUEST   = 6'd10;
  localparam logic [5:0] K_COLON   = 6'd11;
  localparam logic [5:0] K_BANG    = 6'd12;
  localparam logic [5:0] K_EQUAL   = 6'd14;
  localparam logic [5:0] K_GREATER = 6'd16;
  localparam logic [5:0] K_LESS    = 6'd18;
  localparam logic [5:0] K_SLASH   = 6'd20;
  localparam logic [5:0] K_STRING  = 6'd21;
  localparam logic [5:0] K_NUMBER  = 6'd22;
  localparam logic [5:0] K_IDENT   = 6'd23;
  localparam logic [5:0] K_KW0     = 6'd24;
  localparam logic [5:0] K_END     = 6'd40;
  localparam logic [5:0] K_ERROR   = 6'd41;

  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_CHAR    = 2'd1;
  localparam logic [1:0] E_STRING  = 2'd2;
  localparam logic [1:0] E_COMMENT = 2'd3;

  localparam logic [55:0] KW_CHARS [16] = '{
    56'h646e61, 56'h7373616c63, 56'h65736c65, 56'h65736c6166,
    56'h726f66, 56'h6e7566, 56'h6669, 56'h6c696e,
    56'h726f, 56'h746e697270, 56'h6e7275746572, 56'h7265707573,
    56'h73696874, 56'h65757274, 56'h726176, 56'h656c696877};
  localparam logic [2:0] KW_LEN [16] = '{
    3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
    3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFFS_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [LINE_W-1:0] line;
    logic [ERR_W-1:0]  err;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [1:0]            cnt;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t data;
  } qlink_t;

  function automatic logic [5:0] word_kind(logic [55:0] chars, logic [2:0] len);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 0; i < 16; i++) begin
      if (len == KW_LEN[i] && chars == KW_CHARS[i]) k = K_KW0 + 6'(i);
    end
    return k;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

endpackage

// ----- rtl/core/lcl_in_if.sv -----
// Source byte channel: valid/ready handshake carrying one byte or the end mark.
// Depends on nothing.
interface lcl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_source;
  modport source (output valid, char_code, end_of_source, input ready);
  modport sink (input valid, char_code, end_of_source, output ready);
endinterface

// ----- rtl/core/lcl_out_if.sv -----
// Token channel: valid/ready handshake carrying one token record.
// Depends on lcl_pkg for field widths.
interface lcl_out_if;
  logic                       valid;
  logic                       ready;
  logic [lcl_pkg::KIND_W-1:0] token_kind;
  logic [lcl_pkg::OFFS_W-1:0] start_offset;
  logic [lcl_pkg::LEN_W-1:0]  token_length;
  logic [lcl_pkg::LINE_W-1:0] line_number;
  logic [lcl_pkg::ERR_W-1:0]  error_code;
  logic                       last;
  modport source (output valid, token_kind, start_offset, token_length, line_number,
                  error_code, last, input ready);
  modport sink (input valid, token_kind, start_offset, token_length, line_number,
                error_code, last, output ready);
endinterface

// ----- rtl/core/lcl_front.sv -----
// Scanner front end: takes one byte per cycle while the queue is not full, updates scan
// state, and builds the bundle of up to three tokens each byte causes. Depends on lcl_pkg, lcl_in_if.
module lcl_front #(
  parameter int POSITION_BITS = 24,
  parameter int LINE_BITS     = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lcl_in_if.sink               in_ch,
  input  logic                 q_full,
  output lcl_pkg::qlink_t      push
);

  localparam int P = POSITION_BITS;
  localparam int L = LINE_BITS;

  logic [3:0]   mode_r, mode_nxt;
  logic [P-1:0] pos_r, pos_nxt;
  logic [P-1:0] ts_r, ts_nxt;
  logic [L-1:0] line_r, line_nxt;
  logic [55:0]  word_r, word_nxt;
  logic [2:0]   wlen_r, wlen_nxt;

  lcl_pkg::result_t [lcl_pkg::MAX_RES-1:0] res;
  logic [1:0]   n;
  logic         fire, flush_en, idle_en;
  logic [7:0]   c;
  logic [P-1:0] p, span_p, dot_pos, dot_span;
  logic [L-1:0] line_inc;

  function automatic lcl_pkg::result_t mk(logic [5:0] kind, logic [P-1:0] start,
                                          logic [P:0] len, logic [L-1:0] line,
                                          logic [1:0] err);
    lcl_pkg::result_t r;
    logic [P-1:0] ls;
    logic [31:0]  s32, l32, n32;
    ls = len[P] ? '1 : len[P-1:0];
    s32 = 32'(start);
    l32 = 32'(ls);
    n32 = 32'(line);
    r.kind  = kind;
    r.start = s32[lcl_pkg::OFFS_W-1:0];
    r.len   = l32[lcl_pkg::LEN_W-1:0];
    r.line  = n32[lcl_pkg::LINE_W-1:0];
    r.err   = err;
    return r;
  endfunction

  assign fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;
  assign c = in_ch.char_code;
  assign p = pos_r;
  assign span_p = pos_r - ts_r;
  assign dot_pos = (pos_r > ts_r) ? pos_r - 1'b1 : pos_r;
  assign dot_span = dot_pos - ts_r;
  assign line_inc = (line_r == '1) ? line_r : line_r + 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    ts_nxt   = ts_r;
    line_nxt = line_r;
    word_nxt = word_r;
    wlen_nxt = wlen_r;
    pos_nxt  = (pos_r == '1) ? pos_r : pos_r + 1'b1;
    res      = '0;
    n        = 2'd0;
    flush_en = 1'b0;
    idle_en  = 1'b0;
    if (in_ch.end_of_source) begin
      flush_en = 1'b1;
    end else begin
      case (mode_r)
        lcl_pkg::M_BANG, lcl_pkg::M_EQUAL, lcl_pkg::M_GREATER, lcl_pkg::M_LESS: begin
          if (c == "=") begin
            res[n] = mk(lcl_pkg::K_BANG + 6'({mode_r - lcl_pkg::M_BANG, 1'b1}), ts_r,
                        {1'b0, span_p} + 1'b1, line_r, lcl_pkg::E_NONE);
            n = n + 1'b1;
            mode_nxt = lcl_pkg::M_IDLE;
          end else begin
            flush_en = 1'b1;
            idle_en  = 1'b1;
          end
        end
        lcl_pkg::M_SLASH: begin
          if (c == "/") mode_nxt = lcl_pkg::M_LINECOM;
          else if (c == "*") mode_nxt = lcl_pkg::M_BLOCK;
          else begin
            flush_en = 1'b1;
            idle_en  = 1'b1;
          end
        end
        lcl_pkg::M_LINECOM: begin
          if (c == 8'h0a) begin
            mode_nxt = lcl_pkg::M_IDLE;
            idle_en  = 1'b1;
          end
        end
        lcl_pkg::M_BLOCK: begin
          if (c == "*") mode_nxt = lcl_pkg::M_BLOCKSTAR;
          else if (c == 8'h0a) line_nxt = line_inc;
        end
        lcl_pkg::M_BLOCKSTAR: begin
          if (c == "/") mode_nxt = lcl_pkg::M_IDLE;
          else if (c == 8'h0a) begin
            line_nxt = line_inc;
            mode_nxt = lcl_pkg::M_BLOCK;
          end else if (c != "*") mode_nxt = lcl_pkg::M_BLOCK;
        end
        lcl_pkg::M_STRING: begin
          if (c == 8'h22) begin
            res[n] = mk(lcl_pkg::K_STRING, ts_r, {1'b0, span_p} + 1'b1, line_r,
                        lcl_pkg::E_NONE);
            n = n + 1'b1;
            mode_nxt = lcl_pkg::M_IDLE;
          end else if (c == 8'h0a) line_nxt = line_inc;
        end
        lcl_pkg::M_NUM: begin
          if (c == ".") mode_nxt = lcl_pkg::M_NUMDOT;
          else if (!lcl_pkg::is_digit(c)) begin
            flush_en = 1'b1;
            idle_en  = 1'b1;
          end
        end
        lcl_pkg::M_NUMDOT: begin
          if (lcl_pkg::is_digit(c)) mode_nxt = lcl_pkg::M_NUMFRAC;
          else begin
            flush_en = 1'b1;
            idle_en  = 1'b1;
          end
        end
        lcl_pkg::M_NUMFRAC: begin
          if (!lcl_pkg::is_digit(c)) begin
            flush_en = 1'b1;
            idle_en  = 1'b1;
          end
        end
        lcl_pkg::M_WORD: begin
          if (lcl_pkg::is_word(c)) begin
            if (wlen_r != 3'd7) begin
              word_nxt = word_r | (56'(c) << {wlen_r, 3'b000});
              wlen_nxt = wlen_r + 1'b1;
            end
          end else begin
            flush_en = 1'b1;
            idle_en  = 1'b1;
          end
        end
        default: begin
          mode_nxt = lcl_pkg::M_IDLE;
          idle_en  = 1'b1;
        end
      endcase
    end

    if (flush_en) begin
      case (mode_r)
        lcl_pkg::M_BANG, lcl_pkg::M_EQUAL, lcl_pkg::M_GREATER, lcl_pkg::M_LESS: begin
          res[n] = mk(lcl_pkg::K_BANG + 6'({mode_r - lcl_pkg::M_BANG, 1'b0}), ts_r,
                      {1'b0, span_p}, line_r, lcl_pkg::E_NONE);
          n = n + 1'b1;
        end
        lcl_pkg::M_SLASH: begin
          res[n] = mk(lcl_pkg::K_SLASH, ts_r, {1'b0, span_p}, line_r, lcl_pkg::E_NONE);
          n = n + 1'b1;
        end
        lcl_pkg::M_NUM, lcl_pkg::M_NUMFRAC: begin
          res[n] = mk(lcl_pkg::K_NUMBER, ts_r, {1'b0, span_p}, line_r, lcl_pkg::E_NONE);
          n = n + 1'b1;
        end
        lcl_pkg::M_NUMDOT: begin
          res[n] = mk(lcl_pkg::K_NUMBER, ts_r, {1'b0, dot_span}, line_r, lcl_pkg::E_NONE);
          n = n + 1'b1;
          res[n] = mk(lcl_pkg::K_DOT, dot_pos, (P+1)'(1), line_r, lcl_pkg::E_NONE);
          n = n + 1'b1;
        end
        lcl_pkg::M_WORD: begin
          res[n] = mk(lcl_pkg::word_kind(word_r, wlen_r), ts_r, {1'b0, span_p}, line_r,
                      lcl_pkg::E_NONE);
          n = n + 1'b1;
        end
        lcl_pkg::M_STRING: begin
          res[n] = mk(lcl_pkg::K_ERROR, ts_r, {1'b0, span_p}, line_r, lcl_pkg::E_STRING);
          n = n + 1'b1;
        end
        lcl_pkg::M_BLOCK, lcl_pkg::M_BLOCKSTAR: begin
          res[n] = mk(lcl_pkg::K_ERROR, ts_r, {1'b0, span_p}, line_r, lcl_pkg::E_COMMENT);
          n = n + 1'b1;
        end
        default: ;
      endcase
      mode_nxt = lcl_pkg::M_IDLE;
    end

    if (in_ch.end_of_source) begin
      res[n] = mk(lcl_pkg::K_END, p, '0, line_r, lcl_pkg::E_NONE);
      n = n + 1'b1;
      mode_nxt = lcl_pkg::M_IDLE;
      pos_nxt  = '0;
      ts_nxt   = '0;
      line_nxt = L'(1);
      word_nxt = '0;
      wlen_nxt = '0;
    end else if (idle_en) begin
      ts_nxt = p;
      case (c)
        "(": begin res[n] = mk(lcl_pkg::K_LPAREN, p, (P+1)'(1), line_r, lcl_pkg::E_NONE); n = n + 1'b1; end
        ")": begin res[n] = mk(lcl_pkg::K_RPAREN, p, (P+1)'(1), line_r, lcl_pkg::E_NONE); n = n + 1'b1; end
        "{": begin res[n] = mk(lcl_pkg::K_LBRACE, p, (P+1)'(1), line_r, lcl_pkg::E_NONE); n = n + 1'b1; end
        "}": begin res[n] = mk(lcl_pkg::K_RBRACE, p, (P+1)'(1), line_r, lcl_pkg::E_NONE); n = n + 1'b1; end
        ",": begin res[n] = mk(lcl_pkg::K_COMMA, p, (P+1)'(1), line_r, lcl_pkg::E_NONE); n = n + 1'b1; end
        ".": begin res[n] = mk(lcl_pkg::K_DOT, p, (P+1)'(1), line_r, lcl_pkg::E_NONE); n = n + 1'b1; end
        "-": begin res[n] = mk(lcl_pkg::K_MINUS, p, (P+1)'(1), line_r, lcl_pkg::E_NONE); n = n + 1'b1; end
        "+": begin res[n] = mk(lcl_pkg::K_PLUS, p, (P+1)'(1), line_r, lcl_pkg::E_NONE); n = n + 1'b1; end
        ";": begin res[n] = mk(lcl_pkg::K_SEMI, p, (P+1)'(1), line_r, lcl_pkg::E_NONE); n = n + 1'b1; end
        "*": begin res[n] = mk(lcl_pkg::K_STAR, p, (P+1)'(1), line_r, lcl_pkg::E_NONE); n = n + 1'b1; end
        "?": begin res[n] = mk(lcl_pkg::K_QUEST, p, (P+1)'(1), line_r, lcl_pkg::E_NONE); n = n + 1'b1; end
        ":": begin res[n] = mk(lcl_pkg::K_COLON, p, (P+1)'(1), line_r, lcl_pkg::E_NONE); n = n + 1'b1; end
        "!": mode_nxt = lcl_pkg::M_BANG;
        "=": mode_nxt = lcl_pkg::M_EQUAL;
        ">": mode_nxt = lcl_pkg::M_GREATER;
        "<": mode_nxt = lcl_pkg::M_LESS;
        "/": mode_nxt = lcl_pkg::M_SLASH;
        8'h22: mode_nxt = lcl_pkg::M_STRING;
        8'h20, 8'h0d, 8'h09: ;
        8'h0a: line_nxt = line_inc;
        default: begin
          if (lcl_pkg::is_digit(c)) mode_nxt = lcl_pkg::M_NUM;
          else if (lcl_pkg::is_word(c)) begin
            mode_nxt = lcl_pkg::M_WORD;
            word_nxt = 56'(c);
            wlen_nxt = 3'd1;
          end else begin
            res[n] = mk(lcl_pkg::K_ERROR, p, (P+1)'(1), line_r, lcl_pkg::E_CHAR);
            n = n + 1'b1;
          end
        end
      endcase
    end
  end

  assign push.valid    = fire && (n != 2'd0);
  assign push.data.res = res;
  assign push.data.cnt = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lcl_pkg::M_IDLE;
      pos_r  <= '0;
      ts_r   <= '0;
      line_r <= L'(1);
      word_r <= '0;
      wlen_r <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      ts_r   <= ts_nxt;
      line_r <= line_nxt;
      word_r <= word_nxt;
      wlen_r <= wlen_nxt;
    end
  end

endmodule

// ----- rtl/core/lcl_queue.sv -----
// Four-entry queue of token bundles between the scanner and the token output.
// Depends on lcl_pkg.
module lcl_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  lcl_pkg::qlink_t push,
  output logic            full,
  input  logic            pop,
  output lcl_pkg::qlink_t head
);

  lcl_pkg::bundle_t mem [4];
  logic [1:0] wr_r, rd_r;
  logic [2:0] cnt_r;

  assign full       = cnt_r[2];
  assign head.valid = cnt_r != 3'd0;
  assign head.data  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_r] <= push.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push.valid) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + 3'(push.valid) - 3'(pop);
    end
  end

endmodule

// ----- rtl/core/lcl_back.sv -----
// Token output stage: takes bundles from the queue and presents their tokens
// one per cycle while the receiver is ready, marking the bundle's final token. Depends on lcl_pkg, lcl_out_if.
module lcl_back (
  input  logic            clk,
  input  logic            rst_n,
  input  lcl_pkg::qlink_t head,
  output logic            pop,
  lcl_out_if.source       out_ch
);

  lcl_pkg::bundle_t cur_r;
  logic             valid_r;
  logic [1:0]       idx_r;
  logic             is_last, fire;
  lcl_pkg::result_t r;

  assign r       = cur_r.res[idx_r];
  assign is_last = idx_r == cur_r.cnt - 1'b1;
  assign fire    = out_ch.valid && out_ch.ready;
  assign pop     = head.valid && (!valid_r || (fire && is_last));

  assign out_ch.valid        = valid_r;
  assign out_ch.token_kind   = r.kind;
  assign out_ch.start_offset = r.start;
  assign out_ch.token_length = r.len;
  assign out_ch.line_number  = r.line;
  assign out_ch.error_code   = r.err;
  assign out_ch.last         = is_last;

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (pop) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (fire) begin
      if (is_last) valid_r <= 1'b0;
      else idx_r <= idx_r + 1'b1;
    end
  end

endmodule

// ----- rtl/core/lox_char_lexer.sv -----
// Streaming character lexer top level: scanner front end, bundle queue, token output.
// Depends on lcl_pkg, lcl_in_if, lcl_out_if, lcl_front, lcl_queue, lcl_back.
//
// One source byte is accepted per cycle while the four-bundle queue has room;
// each byte yields zero to three tokens, and the output stage sends one token
// per cycle while the receiver is ready, so the sustained rate is one byte per
// cycle unless tokens arrive faster than one per cycle, when the output port sets
// the pace. A byte's tokens pass through the queue memory and the output stage's
// bundle register before they appear on the output. An end-of-source item flushes
// the pending token, sends the end token, and returns the scanner to its reset state.
module lox_char_lexer #(
  parameter int POSITION_BITS = 24,
  parameter int LINE_BITS     = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lcl_in_if.sink    in_ch,
  lcl_out_if.source out_ch
);

  lcl_pkg::qlink_t push, head;
  logic            full, pop;

  lcl_front #(
    .POSITION_BITS(POSITION_BITS),
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .q_full(full), .push(push)
  );

  lcl_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .pop(pop), .head(head)
  );

  lcl_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .pop(pop), .out_ch(out_ch)
  );

endmodule

// ----- sim/tb.sv -----
// Testbench for lox_char_lexer: streams directed and random source bytes and checks every token.
// Depends on lcl_pkg, lcl_in_if, lcl_out_if and the lexer RTL; tokens are predicted in-bench.
module tb;
  import lcl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [5:0]  kind;
    logic [23:0] start;
    logic [23:0] len;
    logic [15:0] line;
    logic [1:0]  err;
    logic        last;
  } token_t;

  localparam int EOS = 256;
  localparam int POS_TOP = 24'hFFFFFF;
  localparam int LINE_TOP = 16'hFFFF;

  logic clk = 0;
  logic rst_n = 0;
  lcl_in_if  src();
  lcl_out_if snk();

  lox_char_lexer dut (.clk(clk), .rst_n(rst_n), .in_ch(src), .out_ch(snk));

  always #2 clk = ~clk;

  token_t tokens_due[$];
  token_t step_tokens[$];
  int errors = 0;
  int requests = 0;
  int tokens_seen = 0;
  int stall_left = 0;

  logic [3:0]  mode;
  int unsigned pos, tstart, line_cnt;
  logic [55:0] wchars;
  int unsigned wlen;

  string kw_names[16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                          "or", "print", "return", "super", "this", "true", "var", "while"};

  function automatic bit digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  task automatic clear_scan();
    mode = M_IDLE;
    pos = 0;
    tstart = 0;
    line_cnt = 1;
    wchars = '0;
    wlen = 0;
  endtask

  task automatic add_token(logic [5:0] kind, int unsigned start, int unsigned len,
                           logic [1:0] err);
    token_t t;
    if (step_tokens.size() >= MAX_RES) return;
    t.kind = kind;
    t.start = start[23:0];
    t.len = (len > POS_TOP) ? 24'hFFFFFF : len[23:0];
    t.line = line_cnt[15:0];
    t.err = err;
    t.last = 0;
    step_tokens.push_back(t);
  endtask

  function automatic int unsigned span(int unsigned e);
    return e > tstart ? e - tstart : 0;
  endfunction

  task automatic bump_line();
    if (line_cnt < LINE_TOP) line_cnt++;
  endtask

  function automatic logic [5:0] classify_word();
    logic [55:0] packed_kw;
    string s;
    for (int k = 0; k < 16; k++) begin
      s = kw_names[k];
      packed_kw = '0;
      for (int i = 0; i < s.len(); i++) packed_kw[8*i +: 8] = s[i];
      if (wlen < 7 && wlen == s.len() && packed_kw == wchars) return K_KW0 + 6'(k);
    end
    return K_IDENT;
  endfunction

  task automatic close_pending(int unsigned p);
    int unsigned dot;
    case (mode)
      M_BANG:    add_token(K_BANG, tstart, span(p), E_NONE);
      M_EQUAL:   add_token(K_EQUAL, tstart, span(p), E_NONE);
      M_GREATER: add_token(K_GREATER, tstart, span(p), E_NONE);
      M_LESS:    add_token(K_LESS, tstart, span(p), E_NONE);
      M_SLASH:   add_token(K_SLASH, tstart, span(p), E_NONE);
      M_NUM, M_NUMFRAC: add_token(K_NUMBER, tstart, span(p), E_NONE);
      M_NUMDOT: begin
        dot = p > tstart ? p - 1 : p;
        add_token(K_NUMBER, tstart, span(dot), E_NONE);
        add_token(K_DOT, dot, 1, E_NONE);
      end
      M_WORD:   add_token(classify_word(), tstart, span(p), E_NONE);
      M_STRING: add_token(K_ERROR, tstart, span(p), E_STRING);
      M_BLOCK, M_BLOCKSTAR: add_token(K_ERROR, tstart, span(p), E_COMMENT);
      default: ;
    endcase
    mode = M_IDLE;
  endtask

  task automatic start_token(logic [7:0] c, int unsigned p);
    tstart = p;
    case (c)
      "(": add_token(K_LPAREN, p, 1, E_NONE);
      ")": add_token(K_RPAREN, p, 1, E_NONE);
      "{": add_token(K_LBRACE, p, 1, E_NONE);
      "}": add_token(K_RBRACE, p, 1, E_NONE);
      ",": add_token(K_COMMA, p, 1, E_NONE);
      ".": add_token(K_DOT, p, 1, E_NONE);
      "-": add_token(K_MINUS, p, 1, E_NONE);
      "+": add_token(K_PLUS, p, 1, E_NONE);
      ";": add_token(K_SEMI, p, 1, E_NONE);
      "*": add_token(K_STAR, p, 1, E_NONE);
      "?": add_token(K_QUEST, p, 1, E_NONE);
      ":": add_token(K_COLON, p, 1, E_NONE);
      "!": mode = M_BANG;
      "=": mode = M_EQUAL;
      ">": mode = M_GREATER;
      "<": mode = M_LESS;
      "/": mode = M_SLASH;
      8'h22: mode = M_STRING;
      8'h20, 8'h0d, 8'h09: ;
      8'h0a: bump_line();
      default: begin
        if (digit(c)) begin
          mode = M_NUM;
        end else if (letter(c)) begin
          mode = M_WORD;
          wchars = {48'h0, c};
          wlen = 1;
        end else begin
          add_token(K_ERROR, p, 1, E_CHAR);
        end
      end
    endcase
  endtask

  task automatic scan_byte(logic [7:0] c, bit eos);
    int unsigned p;
    bit again;
    p = pos;
    again = 0;
    step_tokens.delete();
    if (eos) begin
      close_pending(p);
      add_token(K_END, p, 0, E_NONE);
      step_tokens[step_tokens.size()-1].last = 1;
      clear_scan();
      return;
    end
    case (mode)
      M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
        if (c == "=") begin
          add_token(6'(12 + 2 * (mode - M_BANG) + 1), tstart, span(p) + 1, E_NONE);
          mode = M_IDLE;
        end else again = 1;
      end
      M_SLASH: begin
        if (c == "/") mode = M_LINECOM;
        else if (c == "*") mode = M_BLOCK;
        else again = 1;
      end
      M_LINECOM: if (c == 8'h0a) begin
        mode = M_IDLE;
        start_token(c, p);
      end
      M_BLOCK: begin
        if (c == "*") mode = M_BLOCKSTAR;
        else if (c == 8'h0a) bump_line();
      end
      M_BLOCKSTAR: begin
        if (c == "/") mode = M_IDLE;
        else if (c == 8'h0a) begin
          bump_line();
          mode = M_BLOCK;
        end else if (c != "*") mode = M_BLOCK;
      end
      M_STRING: begin
        if (c == 8'h22) begin
          add_token(K_STRING, tstart, span(p) + 1, E_NONE);
          mode = M_IDLE;
        end else if (c == 8'h0a) bump_line();
      end
      M_NUM: begin
        if (c == ".") mode = M_NUMDOT;
        else if (!digit(c)) again = 1;
      end
      M_NUMDOT: begin
        if (digit(c)) mode = M_NUMFRAC;
        else again = 1;
      end
      M_NUMFRAC: if (!digit(c)) again = 1;
      M_WORD: begin
        if (letter(c)) begin
          if (wlen < 7) begin
            wchars[8*wlen +: 8] = c;
            wlen++;
          end
        end else again = 1;
      end
      default: begin
        mode = M_IDLE;
        start_token(c, p);
      end
    endcase
    if (again) begin
      close_pending(p);
      start_token(c, p);
    end
    if (pos < POS_TOP) pos++;
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1;
  endtask

  // directed source: operators, bad bytes, open string and comment, number-dot, identifiers
  int directed_rows[] = '{"(", 8'hff, ":", 8'h80, 8'h00, "!", "=", "<", "x", ">", "=",
                          8'h22, "a", 8'h0a, EOS, "/", "*", 8'h0a, "*", EOS,
                          "1", "2", ".", "a", EOS};
  int source_rows[$];

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) source_rows.push_back(s[i]);
  endtask

  task automatic build_random(int target);
    string frag;
    int n;
    while (source_rows.size() < target) begin
      case ($urandom_range(0, 13))
        0: add_text(kw_names[$urandom_range(0, 15)]);
        1: begin
          frag = "";
          n = $urandom_range(1, 9);
          for (int i = 0; i < n; i++)
            frag = {frag, string'(byte'($urandom_range(0, 1) ? $urandom_range(97, 122)
                                               : $urandom_range(65, 90)))};
          add_text(frag);
        end
        2: add_text($urandom_range(0, 1) ? "12.5" : "7.");
        3: add_text({"\"", "ab\n", "\""});
        4: add_text("// c\n");
        5: add_text("/* x\n**/");
        6: add_text($urandom_range(0, 1) ? "<=" : "!=");
        7: add_text("()+-;*?:,{}.");
        8: add_text(" \t\r\n");
        9: add_text("_a1 ==>= /");
        10, 11: source_rows.push_back($urandom_range(0, 255));
        12: source_rows.push_back($urandom_range(0, 1) ? 8'h22 : "/");
        default: source_rows.push_back(EOS);
      endcase
    end
    source_rows.push_back(EOS);
  endtask

  task automatic offer(int row);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if (requests < 40) gap = 0;
    if (gap > 0) begin
      src.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src.valid <= 1'b1;
    src.char_code <= (row == EOS) ? 8'($urandom_range(0, 255)) : 8'(row);
    src.end_of_source <= (row == EOS);
    do @(posedge clk); while (!src.ready);
    requests++;
  endtask

  task automatic push_typed(logic [5:0] kind, int unsigned start, logic [1:0] err);
    token_t t;
    t.kind = kind;
    t.start = 24'(start);
    t.len = 24'd1;
    t.line = 16'd1;
    t.err = err;
    t.last = 1;
    tokens_due.push_back(t);
  endtask

  initial begin
    src.valid = 0;
    src.char_code = 0;
    src.end_of_source = 0;
    snk.ready = 0;
    clear_scan();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) source_rows.push_back(directed_rows[i]);
    build_random(110);
    foreach (source_rows[i]) begin
      if (i == directed_rows.size()) stall_left = 60;
      offer(source_rows[i]);
      scan_byte(8'(source_rows[i]), source_rows[i] == EOS);
      if (i == 0) push_typed(K_LPAREN, 0, E_NONE);
      else if (i == 1) push_typed(K_ERROR, 1, E_CHAR);
      else if (i == 2) push_typed(K_COLON, 2, E_NONE);
      else foreach (step_tokens[j]) tokens_due.push_back(step_tokens[j]);
    end
    src.valid <= 1'b0;
    while (tokens_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Streamed %0d source requests through the lexer, %0d tokens checked.",
             requests, tokens_seen);
    $display("Covered operators, comments, strings, numbers, keywords, bad bytes and stalls.");
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    token_t want;
    forever begin
      @(posedge clk);
      if (rst_n && snk.valid && snk.ready) begin
        tokens_seen++;
        if (tokens_due.size() == 0) begin
          errors++;
          $display("%0t unexpected token kind %0d", $realtime, snk.token_kind);
        end else begin
          want = tokens_due.pop_front();
          if (snk.token_kind !== want.kind || snk.start_offset !== want.start ||
              snk.token_length !== want.len || snk.line_number !== want.line ||
              snk.error_code !== want.err || snk.last !== want.last) begin
            errors++;
            $display("%0t expected k%0d s%0d l%0d ln%0d e%0d last%0d, got k%0d s%0d l%0d ln%0d e%0d last%0d",
                     $realtime, want.kind, want.start, want.len, want.line, want.err,
                     want.last, snk.token_kind, snk.start_offset, snk.token_length,
                     snk.line_number, snk.error_code, snk.last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        snk.ready <= 1'b0;
      end else if (tokens_seen < 20) begin
        snk.ready <= 1'b1;
      end else begin
        snk.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
